// ===== sv/azcpt_pkg.sv =====
// Shared types and constants for the audio zero-crossing pulse timer.
// Used by every module of the block; depends on nothing else.
package azcpt_pkg;

    // Sample and weight widths
    localparam int SAMPLE_BITS = 16;
    localparam int WEIGHT_BITS = 9;
    localparam int PROD_BITS   = SAMPLE_BITS + WEIGHT_BITS + 1;
    localparam int SUM_BITS    = PROD_BITS + 1;

    localparam logic [WEIGHT_BITS-1:0] Q8_ONE = WEIGHT_BITS'(256);

    // Configuration register widths
    localparam int TPS_BITS   = 16;
    localparam int LIMIT_BITS = 24;
    localparam int CFG_BITS   = 24;
    localparam int IDX_BITS   = 2;

    // Run length, saturating
    localparam int LEN_BITS = 25;
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    // Stream word widths
    localparam int IN_DATA_BITS  = 2 * SAMPLE_BITS;
    localparam int OUT_DATA_BITS = ((LEN_BITS + 1 + 7) / 8) * 8;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Register indexes
    typedef enum logic [IDX_BITS-1:0] {
        REG_STEREO_MIX = 2'd0,
        REG_PAN_WEIGHT = 2'd1,
        REG_TICKS      = 2'd2,
        REG_LIMIT      = 2'd3
    } reg_idx_t;

    // Reset values
    localparam logic                   RST_STEREO_MIX = 1'b0;
    localparam logic [WEIGHT_BITS-1:0] RST_PAN_WEIGHT = WEIGHT_BITS'(128);
    localparam logic [TPS_BITS-1:0]    RST_TICKS      = TPS_BITS'(324);
    localparam logic [LIMIT_BITS-1:0]  RST_LIMIT      = LIMIT_BITS'(7159090);

    typedef struct packed {
        logic                   stereo_mix;
        logic [WEIGHT_BITS-1:0] pan_weight;
        logic [TPS_BITS-1:0]    ticks_per_sample;
        logic [LIMIT_BITS-1:0]  pulse_limit;
    } cfg_t;

    // Classified word handed from front to back
    typedef struct packed {
        logic eot;
        logic neg;
    } qitem_t;

endpackage

// ===== sv/azcpt_front.sv =====
// Front end: accepts input words, forms the pan-weighted products and
// classifies each word by sign. Depends on azcpt_pkg.
module azcpt_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  azcpt_pkg::cfg_t                      cfg,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [azcpt_pkg::IN_DATA_BITS-1:0]   s_tdata,
    input  logic                                 s_tuser,
    output logic                                 push,
    output azcpt_pkg::qitem_t                    push_item,
    input  logic                                 push_ready
);
    import azcpt_pkg::*;

    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_eot_reg;
    logic signed [PROD_BITS-1:0]   prod_l_reg, prod_r_reg;
    logic [WEIGHT_BITS-1:0]        w_right, w_left;
    logic signed [SAMPLE_BITS-1:0] left, right;
    logic signed [PROD_BITS-1:0]   prod_l_next, prod_r_next;
    logic signed [SUM_BITS-1:0]    mix;
    logic                          take;

    assign left  = s_tdata[SAMPLE_BITS-1:0];
    assign right = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // Weights: mono is left at full weight, right at none
    always_comb
    begin
        if (!cfg.stereo_mix)
            w_right = '0;
        else if (cfg.pan_weight > Q8_ONE)
            w_right = Q8_ONE;
        else
            w_right = cfg.pan_weight;
        w_left = Q8_ONE - w_right;
    end

    assign prod_l_next = left  * $signed({1'b0, w_left});
    assign prod_r_next = right * $signed({1'b0, w_right});

    // Stage register advances when empty or when its word moves on
    assign take     = !s1_valid_reg || push_ready;
    assign s_tready = take;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
            s1_valid_next = s_tvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && s_tvalid)
        begin
            s1_eot_reg <= s_tuser;
            prod_l_reg <= prod_l_next;
            prod_r_reg <= prod_r_next;
        end
    end

    // Sum and sign; zero counts as non-negative
    assign mix = {prod_l_reg[PROD_BITS-1], prod_l_reg}
               + {prod_r_reg[PROD_BITS-1], prod_r_reg};

    assign push          = s1_valid_reg && push_ready;
    assign push_item.eot = s1_eot_reg;
    assign push_item.neg = mix[SUM_BITS-1];

endmodule

// ===== sv/azcpt_queue.sv =====
// Short FIFO of classified words between front and back.
// Depends on azcpt_pkg.
module azcpt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  azcpt_pkg::qitem_t push_item,
    output logic              push_ready,
    input  logic              pop,
    output azcpt_pkg::qitem_t pop_item,
    output logic              pop_valid
);
    import azcpt_pkg::*;

    qitem_t                mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]  count_reg, count_next;

    assign push_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    // Fill count stays within depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    // Push alone raises the count by one
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow push");

    // Pointers stay apart by the fill count
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        QPTR_BITS'(wr_ptr_reg - rd_ptr_reg) == QPTR_BITS'(count_reg))
        else $error("queue pointers disagree with count");

endmodule

// ===== sv/azcpt_back.sv =====
// Back end: tracks runs of equal sign, counts ticks and emits finished
// pulses into the output register. Depends on azcpt_pkg.
module azcpt_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  azcpt_pkg::cfg_t                       cfg,
    input  logic                                  pop_valid,
    input  azcpt_pkg::qitem_t                     pop_item,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [azcpt_pkg::OUT_DATA_BITS-1:0]   m_tdata
);
    import azcpt_pkg::*;

    logic                run_open_reg, run_open_next;
    logic                run_neg_reg, run_neg_next;
    logic [LEN_BITS-1:0] run_len_reg, run_len_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_level_reg, out_level_next;
    logic [LEN_BITS-1:0] out_ticks_reg, out_ticks_next;
    logic [LEN_BITS:0]   len_sum;
    logic [LEN_BITS-1:0] len_sat, tps_ext;
    logic                emit;

    assign pop     = pop_valid && (!out_valid_reg || m_tready);
    assign tps_ext = LEN_BITS'(cfg.ticks_per_sample);
    assign len_sum = {1'b0, run_len_reg} + {1'b0, tps_ext};
    assign len_sat = len_sum[LEN_BITS] ? LEN_MAX : len_sum[LEN_BITS-1:0];

    // Run tracking
    always_comb
    begin
        run_open_next  = run_open_reg;
        run_neg_next   = run_neg_reg;
        run_len_next   = run_len_reg;
        emit           = 1'b0;
        out_level_next = run_neg_reg;
        out_ticks_next = run_len_reg;
        if (pop)
        begin
            if (pop_item.eot)
            begin
                emit          = run_open_reg;
                run_open_next = 1'b0;
            end
            else if (!run_open_reg)
            begin
                run_open_next = 1'b1;
                run_neg_next  = pop_item.neg;
                run_len_next  = tps_ext;
            end
            else if (pop_item.neg != run_neg_reg)
            begin
                emit         = 1'b1;
                run_neg_next = pop_item.neg;
                run_len_next = tps_ext;
            end
            else
            begin
                run_len_next   = len_sat;
                out_ticks_next = len_sat;
                if (len_sat > LEN_BITS'(cfg.pulse_limit))
                begin
                    emit          = 1'b1;
                    run_open_next = 1'b0;
                end
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = emit;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg  <= 1'b0;
            run_neg_reg   <= 1'b0;
            run_len_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_open_reg  <= run_open_next;
            run_neg_reg   <= run_neg_next;
            run_len_reg   <= run_len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_level_reg <= out_level_next;
            out_ticks_reg <= out_ticks_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_BITS-LEN_BITS-1){1'b0}}, out_ticks_reg, out_level_reg};

    // End of tape always closes the run
    a_eot_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_item.eot) |=> !run_open_reg)
        else $error("run still open after end of tape");

    // A pulse is only emitted from an open run
    a_emit_open: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && emit) |-> run_open_reg)
        else $error("pulse emitted without an open run");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !pop)
        else $error("back end popped while result stalled");

endmodule

// ===== sv/audio_zero_crossing_pulse_timer_core.sv =====
// Top level of the audio zero-crossing pulse timer: configuration registers,
// front end, queue and back end. Depends on azcpt_pkg and its submodules.
//
// Usage: audio frames enter on the s_ stream, one word per frame; tdata holds
// left_sample in bits 15:0 and right_sample in bits 31:16, tuser marks end of
// tape. Finished pulses leave on the m_ stream with the level in bit 0 and
// the width in ticks in bits 25:1. A word causes at most one pulse.
// Registers are written through cfg_we/cfg_index/cfg_data while the block is
// idle: 0 stereo mix, 1 pan weight, 2 ticks per frame, 3 pulse limit.
// Throughput is one frame per cycle while m_tready stays high; the front
// product stage, the run tracker and the output register each take a new
// word as the last one moves on. From input acceptance to a valid pulse a
// word is registered in the product register, then in the queue and then
// in the output register.
// Reset clears the queue, closes any run and loads the register defaults.
// When the receiver stalls, the pending pulse holds, the four-word queue
// and the product register fill, and only then does s_tready drop.
module audio_zero_crossing_pulse_timer_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [azcpt_pkg::IDX_BITS-1:0]       cfg_index,
    input  logic [azcpt_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // left_sample [15:0], right_sample [31:16]
    input  logic [azcpt_pkg::IN_DATA_BITS-1:0]   s_tdata,
    // end_of_tape
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // pulse_level [0], pulse_ticks [25:1], zero above
    output logic [azcpt_pkg::OUT_DATA_BITS-1:0]  m_tdata
);
    import azcpt_pkg::*;

    cfg_t   cfg_reg;
    qitem_t push_item, pop_item;
    logic   push, push_ready, pop, pop_valid;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stereo_mix       <= RST_STEREO_MIX;
            cfg_reg.pan_weight       <= RST_PAN_WEIGHT;
            cfg_reg.ticks_per_sample <= RST_TICKS;
            cfg_reg.pulse_limit      <= RST_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEREO_MIX: cfg_reg.stereo_mix       <= cfg_data[0];
                REG_PAN_WEIGHT: cfg_reg.pan_weight       <= cfg_data[WEIGHT_BITS-1:0];
                REG_TICKS:      cfg_reg.ticks_per_sample <= cfg_data[TPS_BITS-1:0];
                REG_LIMIT:      cfg_reg.pulse_limit      <= cfg_data[LIMIT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    azcpt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    azcpt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid)
    );

    azcpt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== sim/audio_zero_crossing_pulse_timer_core_tb.sv =====
// Self-checking bench for audio_zero_crossing_pulse_timer_core: directed and random frames,
// predicted pulses compared word by word on the output stream.
// Depends on azcpt_pkg and the core RTL only.
`timescale 1ns / 100ps

module audio_zero_crossing_pulse_timer_core_tb;

    import azcpt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD = 300;
    localparam int PHASE_WORDS = 215;

    typedef struct {
        logic                level;
        logic [LEN_BITS-1:0] ticks;
    } pulse_t;

    // Predicts pulses from accepted frames and checks the output stream against them
    class pulse_scoreboard;
        logic                   mix_on;
        logic [WEIGHT_BITS-1:0] pan;
        logic [TPS_BITS-1:0]    tps;
        logic [LIMIT_BITS-1:0]  limit;
        bit                     run_live;
        bit                     run_neg;
        logic [LEN_BITS-1:0]    run_len;
        pulse_t                 pending_pulses[$];
        int                     mismatches;
        int                     pulses_seen;

        function new();
            mix_on = RST_STEREO_MIX;
            pan = RST_PAN_WEIGHT;
            tps = RST_TICKS;
            limit = RST_LIMIT;
            run_live = 0;
            run_neg = 0;
            run_len = '0;
            mismatches = 0;
            pulses_seen = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [CFG_BITS-1:0] val);
            case (idx)
                REG_STEREO_MIX: mix_on = val[0];
                REG_PAN_WEIGHT: pan = val[WEIGHT_BITS-1:0];
                REG_TICKS:      tps = val[TPS_BITS-1:0];
                REG_LIMIT:      limit = val[LIMIT_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Sign of the frame: pan-weighted mix in stereo, left alone in mono
        function bit frame_negative(logic signed [SAMPLE_BITS-1:0] l,
                                    logic signed [SAMPLE_BITS-1:0] r);
            longint p;
            longint mix;
            if (!mix_on)
                return l[SAMPLE_BITS-1];
            p = (pan > Q8_ONE) ? 256 : longint'(pan);
            mix = longint'(l) * (256 - p) + longint'(r) * p;
            return mix < 0;
        endfunction

        function void close_run();
            pulse_t p;
            p.level = run_neg;
            p.ticks = run_len;
            pending_pulses.push_back(p);
        endfunction

        function void take_frame(logic [IN_DATA_BITS-1:0] data, logic eot);
            bit neg;
            logic [LEN_BITS:0] sum;
            if (eot)
            begin
                if (run_live)
                    close_run();
                run_live = 0;
                return;
            end
            neg = frame_negative(data[SAMPLE_BITS-1:0], data[2*SAMPLE_BITS-1:SAMPLE_BITS]);
            if (!run_live)
            begin
                run_live = 1;
                run_neg = neg;
                run_len = LEN_BITS'(tps);
                return;
            end
            if (neg != run_neg)
            begin
                close_run();
                run_neg = neg;
                run_len = LEN_BITS'(tps);
                return;
            end
            // same sign: extend, saturate, cut off beyond the limit
            sum = {1'b0, run_len} + (LEN_BITS+1)'(tps);
            run_len = (sum > {1'b0, LEN_MAX}) ? LEN_MAX : sum[LEN_BITS-1:0];
            if (run_len > LEN_BITS'(limit))
            begin
                close_run();
                run_live = 0;
            end
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $time, what);
        endfunction

        function void check_pulse(logic level, logic [LEN_BITS-1:0] ticks);
            pulse_t want;
            pulses_seen++;
            if (pending_pulses.size() == 0)
            begin
                flag($sformatf("unexpected pulse level %0d ticks %0d", level, ticks));
                return;
            end
            want = pending_pulses.pop_front();
            if (want.level !== level)
                flag($sformatf("pulse %0d level: expected %0d, got %0d",
                               pulses_seen, want.level, level));
            if (want.ticks !== ticks)
                flag($sformatf("pulse %0d ticks: expected %0d, got %0d",
                               pulses_seen, want.ticks, ticks));
        endfunction

        function void check_leftover();
            while (pending_pulses.size() > 0)
            begin
                pulse_t want;
                want = pending_pulses.pop_front();
                flag($sformatf("missing pulse level %0d ticks %0d", want.level, want.ticks));
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [IDX_BITS-1:0]      cfg_index = '0;
    logic [CFG_BITS-1:0]      cfg_data = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    // left_sample [15:0], right_sample [31:16]
    logic [IN_DATA_BITS-1:0]  s_tdata = '0;
    // end_of_tape
    logic                     s_tuser = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    // pulse_level [0], pulse_ticks [25:1], zero above
    logic [OUT_DATA_BITS-1:0] m_tdata;

    pulse_scoreboard sb = new();

    int send_idle = 32;
    int recv_idle = 79;
    int frames_in = 0;
    int eot_in = 0;
    int cycle_count = 0;
    int hold_left = 0;
    int hold_idx = 0;
    int hold_marks[2] = '{350, 700};

    audio_zero_crossing_pulse_timer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 clk = ~clk;

    // Watch both streams at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_pulse(m_tdata[0], m_tdata[LEN_BITS:1]);
            if (s_tvalid && s_tready)
            begin
                sb.take_frame(s_tdata, s_tuser);
                frames_in++;
                if (s_tuser)
                    eot_in++;
            end
        end
    end

    // Receiver: random back-pressure plus long holds at fixed word counts
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_idx < 2 && frames_in >= hold_marks[hold_idx])
        begin
            m_tready <= 1'b0;
            hold_left = LONG_HOLD;
            hold_idx++;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Timeout
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_frame(logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] r,
                              logic eot);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r, l};
        s_tuser <= eot;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Sender pause: wait for every predicted pulse, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_pulses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_BITS'(val);
        sb.write_reg(idx, CFG_BITS'(val));
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(bit mix, int pan, int tps, int lim);
        settle();
        write_reg(REG_STEREO_MIX, mix);
        write_reg(REG_PAN_WEIGHT, pan);
        write_reg(REG_TICKS, tps);
        write_reg(REG_LIMIT, lim);
    endtask

    // Sample of a chosen sign, all other bits random
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(bit neg);
        return {neg, 15'($urandom)};
    endfunction

    // Mostly runs of one sign, some long; the rest noise and end-of-tape marks
    task automatic random_phase(int n);
        int made;
        int roll;
        int run_words;
        bit neg;
        logic [SAMPLE_BITS-1:0] l;
        logic [SAMPLE_BITS-1:0] r;
        made = 0;
        while (made < n)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                send_frame(16'($urandom), 16'($urandom), 1'b1);
                made++;
            end
            else if (roll < 18)
            begin
                send_frame(16'($urandom), 16'($urandom), 1'b0);
                made++;
            end
            else
            begin
                neg = $urandom_range(1);
                run_words = ($urandom_range(19) == 0) ? $urandom_range(20, 300)
                                                      : $urandom_range(1, 8);
                repeat (run_words)
                begin
                    l = pick_sample(neg);
                    // both channels share the sign in stereo so the mix keeps it
                    r = sb.mix_on ? pick_sample(neg) : 16'($urandom);
                    send_frame(l, r, 1'b0);
                    made++;
                end
            end
        end
    endtask

    initial
    begin
        int tps;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset settings, mono
        send_frame(16'($urandom), 16'($urandom), 1'b1);   // nothing open, no pulse
        send_frame(16'h7fff, 16'($urandom), 1'b0);
        send_frame(16'h8000, 16'($urandom), 1'b0);        // flip
        send_frame(16'h0000, 16'($urandom), 1'b0);        // zero counts as positive
        send_frame(16'h0001, 16'($urandom), 1'b0);
        send_frame(16'hffff, 16'($urandom), 1'b0);
        send_frame(16'($urandom), 16'($urandom), 1'b1);   // flush open run
        send_frame(16'($urandom), 16'($urandom), 1'b1);

        // Tiny limit: cut-off on the second word, then a fresh run of either sign
        configure(1'b1, 0, 65535, 1);
        send_frame(16'd100, 16'h8000, 1'b0);
        send_frame(16'd200, 16'hffff, 1'b0);
        send_frame(16'hfffb, 16'h7fff, 1'b0);
        send_frame(16'($urandom), 16'($urandom), 1'b1);

        // Right channel only
        configure(1'b1, 256, 1, 16777215);
        send_frame(16'h8000, 16'h7fff, 1'b0);
        send_frame(16'h7fff, 16'h8000, 1'b0);

        // Pan above 256 clamps to right only
        settle();
        write_reg(REG_PAN_WEIGHT, 511);
        send_frame(16'hff9c, 16'd5, 1'b0);

        // Zero ticks per frame, zero mix
        settle();
        write_reg(REG_PAN_WEIGHT, 128);
        write_reg(REG_TICKS, 0);
        send_frame(16'd5, 16'hfffb, 1'b0);
        send_frame(16'hfff9, 16'd3, 1'b0);
        send_frame(16'hfff9, 16'hfff9, 1'b0);
        send_frame(16'($urandom), 16'($urandom), 1'b1);

        // Random phases: sender light, receiver heavy
        configure(1'b0, $urandom_range(511), 324, $urandom_range(1000, 5000));
        random_phase(PHASE_WORDS);
        configure(1'b1, 0, 65535, 16777215);
        random_phase(PHASE_WORDS);

        // Sender heavy, receiver light
        settle();
        send_idle = 79;
        recv_idle = 32;
        configure(1'b1, 256, 1, 1);
        random_phase(PHASE_WORDS);
        tps = $urandom_range(1, 65535);
        configure(1'b1, $urandom_range(511), tps, $urandom_range(1, tps * 10));
        random_phase(PHASE_WORDS);

        // No idling
        settle();
        send_idle = 0;
        recv_idle = 0;
        configure(1'b0, $urandom_range(511), 0, $urandom_range(1, 16777215));
        random_phase(PHASE_WORDS);
        configure(1'b1, 128, $urandom_range(1, 65535), 16777215);
        random_phase(PHASE_WORDS);

        settle();
        sb.check_leftover();

        $display("Covered %0d frames (%0d end-of-tape marks), %0d pulses checked,",
                 frames_in, eot_in, sb.pulses_seen);
        $display("mono and stereo mixing, pan and tick extremes, cut-offs and long stalls; "
                 , "%0d mismatches", sb.mismatches);
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
